FILE: rtl/core/tcp_length_prefixed_deframer_macros.svh
// Assertion macros for the stream deframer.
// Included by the top level; no other dependencies.
`ifndef TCP_LENGTH_PREFIXED_DEFRAMER_MACROS_SVH
`define TCP_LENGTH_PREFIXED_DEFRAMER_MACROS_SVH

`ifndef SYNTH
// Clocked check with explicit clock and active-low reset
`define TLPD_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check on the block clock and reset
`define TLPD_ASSERT(lbl, prop, msg) \
  `TLPD_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define TLPD_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define TLPD_ASSERT(lbl, prop, msg)
`endif

`endif

FILE: rtl/core/tlpd_pkg.sv
// Package for the length-prefixed stream deframer: codes, constants, item types.
// No dependencies.
`timescale 1ns / 1ps

package tlpd_pkg;

  // Header layout
  localparam int unsigned HDR_LEN   = 6;
  localparam int unsigned HDR_CNT_W = 3;
  localparam logic [7:0]  HDR_SYNC  = 8'h06;
  localparam logic [7:0]  HDR_VER   = 8'h10;

  // Register reset and output queue depth
  localparam logic [15:0] MAX_LEN_RESET    = 16'd512;
  localparam int unsigned TLPD_FIFO_DEPTH  = 16;

  // Input function codes
  typedef enum logic [1:0] {
    FUNC_BYTE  = 2'd0,
    FUNC_OPEN  = 2'd1,
    FUNC_CLOSE = 2'd2
  } func_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_SKIP      = 2'd1,
    KIND_MALFORMED = 2'd2,
    KIND_ABORT     = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_in;
  } in_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_out;
    logic       last;
  } out_item_t;

  typedef logic [15:0] cfg_word_t;

endpackage

FILE: rtl/core/tlpd_chan_if.sv
// Valid/ready channel interface carrying one payload item per transfer.
// Payload type is a parameter; types come from tlpd_pkg.
`timescale 1ns / 1ps

interface tlpd_chan_if #(
  parameter type T = logic [7:0]
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/tcp_length_prefixed_deframer.sv
// Channel   | Dir | Payload                         | Transfer when
// ----------+-----+---------------------------------+---------------------
// in_i      | in  | in_item_t  {func, data_in}      | valid && ready
// out_o     | out | out_item_t {kind, data_out,last}| valid && ready
// cfg_i     | in  | max_frame_length (16 bits)      | valid && ready
//
// One input item per cycle while in_i.ready is high. Each item is decoded in the cycle it
// is taken and its results (zero to six) land in an output queue of DEPTH entries, which
// drains one result per cycle while out_o.ready is high. in_i.ready needs room for six
// results when the next byte completes a header, else room for one; at the default depth,
// with out_o.ready high, a stream of frames runs at one byte per cycle. cfg_i is always
// ready. Reset clears link state, counters and the queue; max_frame_length goes to 512.
//
// Length-prefixed stream deframer with cut-through of frame bytes.
// Depends on tlpd_pkg, tlpd_chan_if and the assertion macro header.
`timescale 1ns / 1ps

module tcp_length_prefixed_deframer #(
  parameter int unsigned DEPTH = tlpd_pkg::TLPD_FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tlpd_chan_if.sink   in_i,
  tlpd_chan_if.source out_o,
  tlpd_chan_if.sink   cfg_i
);
  import tlpd_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [PW:0]   DEPTH_W = (PW + 1)'(DEPTH);

  // Framing state
  logic                 link_open_q, link_open_d;
  logic [HDR_CNT_W-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [15:0]          body_left_q, body_left_d;
  logic [15:0]          skip_left_q, skip_left_d;
  logic [15:0]          max_len_q;
  logic [7:0]           hdr_q [HDR_LEN-1];
  logic [7:0]           hdr_d [HDR_LEN-1];

  // Output queue
  out_item_t            mem_q [DEPTH];
  logic [PW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]        cnt_q, cnt_d;

  // Results of the current item
  out_item_t            res [HDR_LEN];
  logic [2:0]           push_n;
  logic [PW-1:0]        wr_idx [HDR_LEN];

  logic                 in_fire, out_fire, hdr_due;
  logic [CW-1:0]        need;
  logic [15:0]          total;
  in_item_t             in_item;

  assign in_item  = in_i.data;
  assign cfg_i.ready = 1'b1;

  // Next byte closes the header: it may push six results
  assign hdr_due = link_open_q && (skip_left_q == '0) && (body_left_q == '0) &&
                   (hdr_cnt_q == HDR_CNT_W'(HDR_LEN - 1));
  assign need       = hdr_due ? CW'(HDR_LEN) : CW'(1);
  assign in_i.ready = (cnt_q <= DEPTH_C - need);
  assign in_fire    = in_i.valid && in_i.ready;

  assign out_o.valid = (cnt_q != '0);
  assign out_o.data  = mem_q[rd_ptr_q];
  assign out_fire    = out_o.valid && out_o.ready;

  assign total = {hdr_q[HDR_LEN-2], in_item.data_in};

  // Decode one item against the framing state
  always_comb begin
    link_open_d = link_open_q;
    hdr_cnt_d   = hdr_cnt_q;
    body_left_d = body_left_q;
    skip_left_d = skip_left_q;
    hdr_d       = hdr_q;
    push_n      = '0;
    for (int k = 0; k < HDR_LEN; k++) begin
      res[k] = '{kind: KIND_BYTE, data_out: 8'h00, last: 1'b0};
    end
    if (in_fire) begin
      unique case (in_item.func)
        FUNC_OPEN: begin
          if (!link_open_q) begin
            link_open_d = 1'b1;
            hdr_cnt_d   = '0;
            body_left_d = '0;
            skip_left_d = '0;
          end
        end
        FUNC_CLOSE: begin
          if (link_open_q) begin
            // abort only when a header was in progress or body bytes were still due
            if ((hdr_cnt_q != '0) || (body_left_q != '0)) begin
              res[0].kind = KIND_ABORT;
              push_n      = 3'd1;
            end
            link_open_d = 1'b0;
            hdr_cnt_d   = '0;
            body_left_d = '0;
            skip_left_d = '0;
          end
        end
        FUNC_BYTE: begin
          if (link_open_q) begin
            priority if (skip_left_q != '0) begin
              skip_left_d = skip_left_q - 16'd1;
            end else if (body_left_q != '0) begin
              body_left_d     = body_left_q - 16'd1;
              res[0].data_out = in_item.data_in;
              res[0].last     = (body_left_q == 16'd1);
              push_n          = 3'd1;
            end else if (!hdr_due) begin
              for (int i = 0; i < HDR_LEN - 1; i++) begin
                if (hdr_cnt_q == HDR_CNT_W'(i)) hdr_d[i] = in_item.data_in;
              end
              hdr_cnt_d = hdr_cnt_q + HDR_CNT_W'(1);
            end else begin
              hdr_cnt_d = '0;
              priority if ((hdr_q[0] != HDR_SYNC) || (hdr_q[1] != HDR_VER) ||
                           (total < 16'(HDR_LEN))) begin
                res[0].kind = KIND_MALFORMED;
                push_n      = 3'd1;
                link_open_d = 1'b0;
                body_left_d = '0;
                skip_left_d = '0;
              end else if (total > max_len_q) begin
                skip_left_d = total - 16'(HDR_LEN);
                res[0].kind = KIND_SKIP;
                push_n      = 3'd1;
              end else begin
                // header complete: pass all six bytes on
                body_left_d = total - 16'(HDR_LEN);
                for (int i = 0; i < HDR_LEN - 1; i++) begin
                  res[i].data_out = hdr_q[i];
                end
                res[HDR_LEN-1].data_out = in_item.data_in;
                res[HDR_LEN-1].last     = (total == 16'(HDR_LEN));
                push_n                  = 3'(HDR_LEN);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Queue write slots, wrapped at DEPTH
  always_comb begin
    logic [PW:0] sum;
    logic [PW:0] adv;
    for (int k = 0; k < HDR_LEN; k++) begin
      sum = {1'b0, wr_ptr_q} + (PW + 1)'(k);
      if (sum >= DEPTH_W) sum = sum - DEPTH_W;
      wr_idx[k] = sum[PW-1:0];
    end
    adv = {1'b0, wr_ptr_q} + (PW + 1)'(push_n);
    if (adv >= DEPTH_W) adv = adv - DEPTH_W;
    wr_ptr_d = adv[PW-1:0];
  end

  // Read pointer and fill count
  always_comb begin
    rd_ptr_d = rd_ptr_q;
    if (out_fire) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    cnt_d = cnt_q + CW'(push_n) - CW'(out_fire);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_open_q <= 1'b0;
      hdr_cnt_q   <= '0;
      body_left_q <= '0;
      skip_left_q <= '0;
      max_len_q   <= MAX_LEN_RESET;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      cnt_q       <= '0;
    end else begin
      link_open_q <= link_open_d;
      hdr_cnt_q   <= hdr_cnt_d;
      body_left_q <= body_left_d;
      skip_left_q <= skip_left_d;
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      cnt_q       <= cnt_d;
      if (cfg_i.valid && cfg_i.ready) max_len_q <= cfg_i.data;
    end
  end

  // Header bytes and queue entries
  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
    for (int k = 0; k < HDR_LEN; k++) begin
      if (3'(k) < push_n) mem_q[wr_idx[k]] <= res[k];
    end
  end

  // Checks
`include "tcp_length_prefixed_deframer_macros.svh"

  `TLPD_ASSERT(a_cnt_bound, cnt_q <= DEPTH_C, "output queue overfilled")
  `TLPD_ASSERT(a_hdr_bound, hdr_cnt_q < HDR_CNT_W'(HDR_LEN), "header count out of range")
  `TLPD_ASSERT(a_body_skip_excl,
               !((body_left_q != '0) && (skip_left_q != '0)),
               "body and skip both active")
  `TLPD_ASSERT(a_closed_idle,
               !link_open_q |->
                 ((hdr_cnt_q == '0) && (body_left_q == '0) && (skip_left_q == '0)),
               "counts live on closed link")
  `TLPD_ASSERT(a_cnt_track,
               (out_fire && !in_fire) |=> (cnt_q == $past(cnt_q) - CW'(1)),
               "fill count lost a pop")

endmodule

FILE: sim/tlpd_stream_checker.sv
// Scoreboard for the stream deframer: tracks the framing state from observed
// transfers, predicts the results and compares them. Depends on tlpd_pkg.
`timescale 1ns / 1ps

module tlpd_stream_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  tlpd_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  tlpd_pkg::out_item_t out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  tlpd_pkg::cfg_word_t cfg_data_i,
  output int unsigned         pending_o,
  output int unsigned         fail_count_o
);
  import tlpd_pkg::*;

  // Shadow of the framing state
  logic [15:0]          max_len_q;
  logic                 link_up_q;
  logic [7:0]           hdr_q [HDR_LEN];
  logic [HDR_CNT_W-1:0] hdr_cnt_q;
  logic [15:0]          body_left_q;
  logic [15:0]          skip_left_q;

  out_item_t   frame_results_q [$];
  int unsigned fails;

  task automatic add_result(input kind_e k, input logic [7:0] d, input logic l);
    out_item_t r;
    r.kind     = k;
    r.data_out = d;
    r.last     = l;
    frame_results_q.push_back(r);
  endtask

  task automatic clear_counts();
    hdr_cnt_q   = '0;
    body_left_q = '0;
    skip_left_q = '0;
  endtask

  // Advance the framing state by one accepted input item
  task automatic deframe_item(input in_item_t it);
    logic [15:0] total;
    int          i;
    case (it.func)
      FUNC_OPEN: begin
        if (!link_up_q) begin
          link_up_q = 1'b1;
          clear_counts();
        end
      end
      FUNC_CLOSE: begin
        if (link_up_q) begin
          // abort only when a header is in progress or body bytes are still due
          if (hdr_cnt_q != 0 || body_left_q != 0) add_result(KIND_ABORT, 8'h00, 1'b0);
          link_up_q = 1'b0;
          clear_counts();
        end
      end
      FUNC_BYTE: begin
        if (!link_up_q) begin
        end else if (skip_left_q != 0) begin
          skip_left_q = skip_left_q - 16'd1;
        end else if (body_left_q != 0) begin
          body_left_q = body_left_q - 16'd1;
          add_result(KIND_BYTE, it.data_in, body_left_q == 0);
        end else begin
          hdr_q[hdr_cnt_q] = it.data_in;
          hdr_cnt_q = hdr_cnt_q + 1'b1;
          if (hdr_cnt_q == HDR_LEN) begin
            total     = {hdr_q[4], hdr_q[5]};
            hdr_cnt_q = '0;
            if (hdr_q[0] != HDR_SYNC || hdr_q[1] != HDR_VER || total < HDR_LEN) begin
              add_result(KIND_MALFORMED, 8'h00, 1'b0);
              link_up_q = 1'b0;
              clear_counts();
            end else if (total > max_len_q) begin
              skip_left_q = total - 16'(HDR_LEN);
              add_result(KIND_SKIP, 8'h00, 1'b0);
            end else begin
              body_left_q = total - 16'(HDR_LEN);
              for (i = 0; i < HDR_LEN; i++)
                add_result(KIND_BYTE, hdr_q[i], i == HDR_LEN - 1 && body_left_q == 0);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // Predict on input transfers, compare on output transfers
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_item;
    if (!rst_ni) begin
      max_len_q = MAX_LEN_RESET;
      link_up_q = 1'b0;
      clear_counts();
      frame_results_q.delete();
      fails = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) max_len_q = cfg_data_i;
      if (in_valid_i && in_ready_i) deframe_item(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (frame_results_q.size() == 0) begin
          $error("unexpected result: kind %0d data_out %0h last %0b",
                 out_data_i.kind, out_data_i.data_out, out_data_i.last);
          fails++;
        end else begin
          exp_item = frame_results_q.pop_front();
          if (out_data_i.kind !== exp_item.kind) begin
            $error("kind: expected %0d, actual %0d", exp_item.kind, out_data_i.kind);
            fails++;
          end
          if (out_data_i.data_out !== exp_item.data_out) begin
            $error("data_out: expected %0h, actual %0h",
                   exp_item.data_out, out_data_i.data_out);
            fails++;
          end
          if (out_data_i.last !== exp_item.last) begin
            $error("last: expected %0b, actual %0b", exp_item.last, out_data_i.last);
            fails++;
          end
        end
      end
      pending_o    <= frame_results_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

FILE: sim/tb_tcp_length_prefixed_deframer.sv
// Testbench top for the stream deframer: clock, reset, stimulus and verdict.
// Depends on tlpd_pkg, tlpd_chan_if, the deframer RTL and tlpd_stream_checker.
`timescale 1ns / 1ps

module tb_tcp_length_prefixed_deframer;
  import tlpd_pkg::*;

  localparam int unsigned RESET_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned RANDOM_ITEMS = 310;
  localparam int unsigned NUM_PHASES   = 7;
  localparam int unsigned CFG_SETTLE   = 4;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam logic [1:0]  FUNC_UNUSED  = 2'd3;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Stimulus-side view of the link and pacing controls
  logic        link_up;
  logic [15:0] cur_max;
  bit          no_idle;
  bit          hold_req;
  int unsigned counted;
  int unsigned cycle_count;
  int unsigned pending;
  int unsigned fail_count;

  always #6 clk = ~clk;

  tlpd_chan_if #(.T(in_item_t))  in_ch  ();
  tlpd_chan_if #(.T(out_item_t)) out_ch ();
  tlpd_chan_if #(.T(cfg_word_t)) cfg_ch ();

  tcp_length_prefixed_deframer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  tlpd_stream_checker u_frame_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_ch.valid),
    .in_ready_i   (in_ch.ready),
    .in_data_i    (in_ch.data),
    .out_valid_i  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_data_i   (out_ch.data),
    .cfg_valid_i  (cfg_ch.valid),
    .cfg_ready_i  (cfg_ch.ready),
    .cfg_data_i   (cfg_ch.data),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  function automatic int unsigned draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 12);
  endfunction

  // One input transfer, after a random gap
  task automatic push_item(input logic [1:0] fn, input logic [7:0] b);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{func: fn, data_in: b};
    do @(posedge clk); while (!in_ch.ready);
    // only items that change or use the link count toward the total
    if ((fn == FUNC_BYTE && link_up) || (fn == FUNC_OPEN && !link_up) ||
        (fn == FUNC_CLOSE && link_up))
      counted++;
    if (fn == FUNC_OPEN) link_up = 1'b1;
    if (fn == FUNC_CLOSE) link_up = 1'b0;
  endtask

  task automatic open_link();
    push_item(FUNC_OPEN, 8'($urandom_range(0, 255)));
  endtask

  task automatic close_link();
    push_item(FUNC_CLOSE, 8'($urandom_range(0, 255)));
  endtask

  // First n_bytes of a frame: sync, version, two free bytes, length, body
  task automatic send_frame(input logic [7:0] b0, input logic [7:0] b1,
                            input logic [15:0] total, input int unsigned n_bytes);
    int unsigned i;
    logic [7:0]  v;
    for (i = 0; i < n_bytes; i++) begin
      case (i)
        0:       v = b0;
        1:       v = b1;
        4:       v = total[15:8];
        5:       v = total[7:0];
        default: v = 8'($urandom_range(0, 255));
      endcase
      push_item(FUNC_BYTE, v);
    end
  endtask

  // Let the block drain before touching the register or finishing
  task automatic wait_idle(input int unsigned settle);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_max(input logic [15:0] v);
    wait_idle(CFG_SETTLE);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cur_max = v;
  endtask

  // One random unit: mostly whole frames, some broken ones and some noise
  task automatic random_unit();
    int unsigned r;
    int unsigned total;
    int unsigned n;
    logic [7:0]  b0;
    logic [7:0]  b1;
    if (!link_up) open_link();
    r = $urandom_range(0, 99);
    if (r < 58 || (r < 70 && cur_max == 16'hFFFF)) begin
      // well-formed frame, occasionally exactly at the limit
      total = 6 + $urandom_range(0, 14);
      if (cur_max >= HDR_LEN && cur_max <= 40 && $urandom_range(0, 3) == 0) total = cur_max;
      send_frame(HDR_SYNC, HDR_VER, 16'(total), total);
    end else if (r < 70) begin
      // oversized frame: skip it whole, or close while skipping
      total = cur_max + 1 + $urandom_range(0, 8);
      if (total < HDR_LEN) total = HDR_LEN + $urandom_range(0, 8);
      if ($urandom_range(0, 4) == 0 || total > 16'hFFFF) total = 16'hFFFF;
      if (total <= 30) begin
        send_frame(HDR_SYNC, HDR_VER, 16'(total), total);
      end else begin
        send_frame(HDR_SYNC, HDR_VER, 16'(total), HDR_LEN + $urandom_range(0, 10));
        close_link();
      end
    end else if (r < 80) begin
      // malformed header closes the link
      b0    = HDR_SYNC;
      b1    = HDR_VER;
      total = 6 + $urandom_range(0, 14);
      case ($urandom_range(0, 2))
        0:       b0 = 8'($urandom_range(0, 255)) ^ 8'h00;
        1:       b1 = 8'($urandom_range(0, 255));
        default: total = $urandom_range(0, 5);
      endcase
      if (b0 == HDR_SYNC && b1 == HDR_VER && total >= HDR_LEN) b0 = HDR_SYNC ^ 8'h01;
      send_frame(b0, b1, 16'(total), HDR_LEN);
      link_up = 1'b0;
    end else if (r < 92) begin
      // peer close somewhere inside or right after a frame
      total = 6 + $urandom_range(0, 14);
      n     = $urandom_range(1, total);
      send_frame(HDR_SYNC, HDR_VER, 16'(total), n);
      close_link();
    end else begin
      // items the block ignores, or a close followed by bytes on the closed link
      case ($urandom_range(0, 2))
        0: push_item(FUNC_UNUSED, 8'($urandom_range(0, 255)));
        1: open_link();
        default: begin
          close_link();
          repeat ($urandom_range(1, 3)) push_item(FUNC_BYTE, 8'($urandom_range(0, 255)));
          close_link();
        end
      endcase
    end
  endtask

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result receiver with random stalls and one long hold-off on request
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        stall = draw_gap();
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid && !hold_req) @(posedge clk);
    end
  end

  // Stimulus and verdict
  initial begin
    int unsigned p;
    logic [15:0] phase_max;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= MAX_LEN_RESET;
    link_up     = 1'b0;
    cur_max     = MAX_LEN_RESET;
    no_idle     = 1'b0;
    hold_req    = 1'b0;
    counted     = 0;
    cycle_count = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: ignored items on a closed link, double open, shortest frame,
    // close inside a header, short length field
    push_item(FUNC_BYTE, 8'hFF);
    push_item(FUNC_CLOSE, 8'h00);
    push_item(FUNC_UNUSED, 8'hFF);
    open_link();
    open_link();
    send_frame(HDR_SYNC, HDR_VER, 16'd6, 6);
    send_frame(HDR_SYNC, HDR_VER, 16'd20, 3);
    close_link();
    open_link();
    send_frame(HDR_SYNC, HDR_VER, 16'd5, 6);
    link_up = 1'b0;

    // Random phases over several length limits, extremes included
    counted = 0;
    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       phase_max = MAX_LEN_RESET;
        1:       phase_max = 16'd6;
        2:       phase_max = 16'd0;
        3:       phase_max = 16'hFFFF;
        4:       phase_max = 16'd24;
        5:       phase_max = 16'd100;
        default: phase_max = 16'd7;
      endcase
      if (p > 0) write_max(phase_max);
      no_idle = (p == 1 || p == 4);
      // back-pressure: stop the receiver while the sender streams frames
      if (p == 4) hold_req = 1'b1;
      while (counted < (p + 1) * RANDOM_ITEMS / NUM_PHASES) random_unit();
    end

    wait_idle(DRAIN_CYCLES);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
